@@ sv/ahf_pkg.sv @@
// package: types, constants and the hex lookup for the AVR line framer
package ahf_pkg;

	localparam int RING_DEPTH    = 128;
	localparam int MAX_MSG_BYTES = 14;

	localparam int SLOT_W  = $clog2(RING_DEPTH);
	localparam int CNT_W   = $clog2(RING_DEPTH + 1);
	localparam int FRAME_W = MAX_MSG_BYTES * 8;
	localparam int NIB_W   = $clog2(2 * MAX_MSG_BYTES + 1);
	localparam int LEN_W   = 4;
	localparam int ENTRY_W = LEN_W + FRAME_W;

	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_NL   = 8'h0A;
	localparam logic [3:0] NIB_MASK = 4'hF;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_CHAR   = 3'd0,
		STAT_STORED = 3'd1,
		STAT_DROP   = 3'd2,
		STAT_IGNORE = 3'd3,
		STAT_EMPTY  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_STAR,
		S_HEX,
		S_SEMI,
		S_NL
	} state_t;

	typedef struct packed {
		cmd_t        command;
		logic [7:0]  msg_bits;
		logic [63:0] msg_upper;
		logic [47:0] msg_lower;
		logic        listener_present;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  out_char;
		logic        line_end;
		logic [31:0] dropped_total;
	} res_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [3:0] n;
		n = nib & NIB_MASK;
		if (n < 4'd10) begin
			hex_char = 8'h30 + {4'd0, n};
		end else begin
			hex_char = 8'h37 + {4'd0, n};
		end
	endfunction

endpackage

@@ sv/ahf_if.sv @@
// valid/ready channel interfaces for framer requests and results
interface ahf_req_if;
	logic          valid;
	logic          ready;
	ahf_pkg::req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ahf_res_if;
	logic          valid;
	logic          ready;
	ahf_pkg::res_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ sv/avr_hex_line_ring_framer_core.sv @@
// AVR raw hex line framer: frame ring memory and character sequencer
// push: one registered result, in the cycle after the request is taken; next request once that result leaves
// pop: 2*n+3 characters for an n-byte frame, '*' after the ring read (rd_entry_q), then one
//   character per cycle from the shared nibble shifter while results are taken; busy until
//   the newline leaves; pop of an empty ring: one result, registered in the cycle after the request
// reset (arst_n low, async) empties the ring and clears the drop counter; ring memory is not cleared
module avr_hex_line_ring_framer_core (
	input  logic      clk,
	input  logic      arst_n,
	ahf_req_if.sink   req_ch,
	ahf_res_if.source res_ch
);

	ahf_pkg::state_t state_q, state_d;

	logic [ahf_pkg::ENTRY_W-1:0] mem [ahf_pkg::RING_DEPTH];
	logic [ahf_pkg::ENTRY_W-1:0] rd_entry_q;

	logic [ahf_pkg::SLOT_W-1:0]  wr_q, rd_q;
	logic [ahf_pkg::CNT_W-1:0]   count_q;
	logic [31:0]                 drop_q;
	logic [ahf_pkg::FRAME_W-1:0] shift_q;
	logic [ahf_pkg::NIB_W-1:0]   nib_q;

	logic           res_valid_q;
	ahf_pkg::res_t  res_q, res_d;

	logic req_ready, req_fire, out_free, out_load;
	logic do_write, do_read, drop_inc, shift_load, shift_step;
	logic [4:0] nbytes;
	logic [111:0] frame_in;
	logic [ahf_pkg::ENTRY_W-1:0] wr_entry;

	assign req_fire = req_ch.valid && req_ready;
	assign out_free = !res_valid_q || res_ch.ready;
	assign nbytes   = req_ch.data.msg_bits[7:3];
	assign frame_in = {req_ch.data.msg_upper, req_ch.data.msg_lower};
	assign wr_entry = {nbytes[ahf_pkg::LEN_W-1:0], frame_in[111 -: ahf_pkg::FRAME_W]};

	assign req_ch.ready = req_ready;
	assign res_ch.valid = res_valid_q;
	assign res_ch.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ahf_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		out_load   = 1'b0;
		do_write   = 1'b0;
		do_read    = 1'b0;
		drop_inc   = 1'b0;
		shift_load = 1'b0;
		shift_step = 1'b0;
		res_d.status        = ahf_pkg::STAT_CHAR;
		res_d.out_char      = 8'd0;
		res_d.line_end      = 1'b0;
		res_d.dropped_total = drop_q;
		case (state_q)
			ahf_pkg::S_IDLE: begin
				req_ready = out_free;
				if (req_fire) begin
					res_d.line_end = 1'b1;
					out_load       = 1'b1;
					if (req_ch.data.command == ahf_pkg::CMD_PUSH) begin
						if (!req_ch.data.listener_present || nbytes == 5'd0 ||
						    nbytes > 5'(ahf_pkg::MAX_MSG_BYTES)) begin
							res_d.status = ahf_pkg::STAT_IGNORE;
						end else if (count_q == ahf_pkg::CNT_W'(ahf_pkg::RING_DEPTH)) begin
							res_d.status        = ahf_pkg::STAT_DROP;
							res_d.dropped_total = drop_q + 32'd1;
							drop_inc            = 1'b1;
						end else begin
							res_d.status = ahf_pkg::STAT_STORED;
							do_write     = 1'b1;
						end
					end else if (count_q == '0) begin
						res_d.status = ahf_pkg::STAT_EMPTY;
					end else begin
						// line starts once the ring read has landed
						out_load = 1'b0;
						do_read  = 1'b1;
						state_d  = ahf_pkg::S_STAR;
					end
				end
			end
			ahf_pkg::S_STAR: begin
				if (out_free) begin
					out_load       = 1'b1;
					shift_load     = 1'b1;
					res_d.out_char = ahf_pkg::CH_STAR;
					state_d        = ahf_pkg::S_HEX;
				end
			end
			ahf_pkg::S_HEX: begin
				if (out_free) begin
					out_load       = 1'b1;
					shift_step     = 1'b1;
					res_d.out_char = ahf_pkg::hex_char(shift_q[ahf_pkg::FRAME_W-1 -: 4]);
					if (nib_q == ahf_pkg::NIB_W'(1)) begin
						state_d = ahf_pkg::S_SEMI;
					end
				end
			end
			ahf_pkg::S_SEMI: begin
				if (out_free) begin
					out_load       = 1'b1;
					res_d.out_char = ahf_pkg::CH_SEMI;
					state_d        = ahf_pkg::S_NL;
				end
			end
			ahf_pkg::S_NL: begin
				if (out_free) begin
					out_load       = 1'b1;
					res_d.out_char = ahf_pkg::CH_NL;
					res_d.line_end = 1'b1;
					state_d        = ahf_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ahf_pkg::S_IDLE;
			end
		endcase
	end

	// ring memory: one write or one registered read per cycle
	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[wr_q] <= wr_entry;
		end
		if (do_read) begin
			rd_entry_q <= mem[rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q        <= '0;
			rd_q        <= '0;
			count_q     <= '0;
			drop_q      <= 32'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (do_write) begin
				wr_q    <= (wr_q == ahf_pkg::SLOT_W'(ahf_pkg::RING_DEPTH - 1)) ? '0 : wr_q + 1'b1;
				count_q <= count_q + 1'b1;
			end
			if (do_read) begin
				rd_q    <= (rd_q == ahf_pkg::SLOT_W'(ahf_pkg::RING_DEPTH - 1)) ? '0 : rd_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
			if (drop_inc) begin
				drop_q <= drop_q + 32'd1;
			end
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// nibble shifter: high nibble of the oldest byte sits at the top
	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q <= res_d;
		end
		if (shift_load) begin
			shift_q <= rd_entry_q[ahf_pkg::FRAME_W-1:0];
			nib_q   <= ahf_pkg::NIB_W'({rd_entry_q[ahf_pkg::ENTRY_W-1 -: ahf_pkg::LEN_W], 1'b0});
		end else if (shift_step) begin
			shift_q <= {shift_q[ahf_pkg::FRAME_W-5:0], 4'd0};
			nib_q   <= nib_q - 1'b1;
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ahf_pkg::CNT_W'(ahf_pkg::RING_DEPTH))
		else $error("ring occupancy above depth");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_ch.ready |-> state_q == ahf_pkg::S_IDLE)
		else $error("request taken while a line is in progress");

	a_pop_starts_line: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req_ch.data.command == ahf_pkg::CMD_POP && count_q != '0)
		|=> state_q == ahf_pkg::S_STAR && !$stable(rd_q))
		else $error("pop of a filled ring did not start a line");

	a_status_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_ch.valid && res_ch.data.status != ahf_pkg::STAT_CHAR) |->
		res_ch.data.out_char == 8'd0 && res_ch.data.line_end)
		else $error("non-character result malformed");

	a_line_end_newline: assert property (@(posedge clk) disable iff (!arst_n)
		(res_ch.valid && res_ch.data.status == ahf_pkg::STAT_CHAR && res_ch.data.line_end)
		|-> res_ch.data.out_char == ahf_pkg::CH_NL)
		else $error("line end on a character other than newline");
`endif

endmodule

@@ bench/tb_ahf_line_checker.sv @@
// result checker for the AVR hex line framer: ring predictor and per-character compare
`timescale 1ns / 100ps
module tb_ahf_line_checker (
	input  logic clk,
	input  logic arst_n,
	ahf_req_if   req_ch,
	ahf_res_if   res_ch,
	output int   mismatches,
	output int   outstanding,
	output int   ring_level,
	output int   chars_checked
);
	import ahf_pkg::*;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_A    = 8'h41;
	localparam int         MAX_REPORTS = 10;

	logic [63:0] held_upper [RING_DEPTH];
	logic [47:0] held_lower [RING_DEPTH];
	logic [3:0]  held_len   [RING_DEPTH];
	int unsigned head_idx;
	int unsigned tail_idx;
	int unsigned held_count;
	logic [31:0] drop_tally;
	res_t        due_results [$];

	function automatic logic [7:0] nibble_ascii(input logic [3:0] v);
		if (v < 4'd10) begin
			return ASCII_ZERO + {4'd0, v};
		end
		return ASCII_A + {4'd0, v} - 8'd10;
	endfunction

	function automatic res_t line_result(input status_t st, input logic [7:0] ch,
			input logic last);
		res_t r;
		r.status        = st;
		r.out_char      = ch;
		r.line_end      = last;
		r.dropped_total = drop_tally;
		return r;
	endfunction

	task automatic predict_framer_response(input req_t rq);
		int          nbytes;
		logic [111:0] frame;
		logic [7:0]  b;
		if (rq.command == CMD_PUSH) begin
			nbytes = int'(rq.msg_bits >> 3);
			// listener check first, then the length window
			if (!rq.listener_present || nbytes == 0 || nbytes > MAX_MSG_BYTES) begin
				due_results.push_back(line_result(STAT_IGNORE, 8'h00, 1'b1));
			end else if (held_count == RING_DEPTH) begin
				drop_tally = drop_tally + 32'd1;
				due_results.push_back(line_result(STAT_DROP, 8'h00, 1'b1));
			end else begin
				held_upper[tail_idx] = rq.msg_upper;
				held_lower[tail_idx] = rq.msg_lower;
				held_len[tail_idx]   = nbytes[3:0];
				tail_idx   = (tail_idx + 1) % RING_DEPTH;
				held_count = held_count + 1;
				due_results.push_back(line_result(STAT_STORED, 8'h00, 1'b1));
			end
		end else begin
			if (held_count == 0) begin
				due_results.push_back(line_result(STAT_EMPTY, 8'h00, 1'b1));
			end else begin
				frame  = {held_upper[head_idx], held_lower[head_idx]};
				nbytes = int'(held_len[head_idx]);
				head_idx   = (head_idx + 1) % RING_DEPTH;
				held_count = held_count - 1;
				due_results.push_back(line_result(STAT_CHAR, CH_STAR, 1'b0));
				for (int i = 0; i < nbytes; i++) begin
					b = frame[111 - 8 * i -: 8];
					due_results.push_back(line_result(STAT_CHAR, nibble_ascii(b[7:4]), 1'b0));
					due_results.push_back(line_result(STAT_CHAR, nibble_ascii(b[3:0]), 1'b0));
				end
				due_results.push_back(line_result(STAT_CHAR, CH_SEMI, 1'b0));
				due_results.push_back(line_result(STAT_CHAR, CH_NL, 1'b1));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t got;
		if (!arst_n) begin
			head_idx   = 0;
			tail_idx   = 0;
			held_count = 0;
			drop_tally = '0;
			due_results.delete();
			ring_level  <= 0;
			outstanding <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				got = res_ch.data;
				chars_checked++;
				if (due_results.size() == 0) begin
					if (mismatches < MAX_REPORTS) begin
						$display("unexpected result: status %0d char %h end %b drops %0d",
							got.status, got.out_char, got.line_end, got.dropped_total);
					end
					mismatches++;
				end else begin
					want = due_results.pop_front();
					if (got.status !== want.status || got.out_char !== want.out_char ||
							got.line_end !== want.line_end ||
							got.dropped_total !== want.dropped_total) begin
						if (mismatches < MAX_REPORTS) begin
							$display("mismatch: expected status %0d char %h end %b drops %0d",
								want.status, want.out_char, want.line_end,
								want.dropped_total);
							$display("          actual   status %0d char %h end %b drops %0d",
								got.status, got.out_char, got.line_end, got.dropped_total);
						end
						mismatches++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				predict_framer_response(req_ch.data);
			end
			ring_level  <= int'(held_count);
			outstanding <= due_results.size();
		end
	end

endmodule

@@ bench/tb_avr_hex_line_ring_framer_core.sv @@
// testbench top for the AVR hex line framer: request stimulus, result back-pressure, verdict
`timescale 1ns / 100ps
module tb_avr_hex_line_ring_framer_core;
	import ahf_pkg::*;

	localparam int IDLE_LIMIT  = 1000;
	localparam int TAIL_CYCLES = 40;
	localparam int MIX_ITEMS   = 30;
	localparam int TAIL_ITEMS  = 10;
	localparam int DROP_ITEMS  = 8;

	logic clk = 1'b0;
	logic arst_n;

	ahf_req_if req_ch ();
	ahf_res_if res_ch ();

	int mismatches;
	int outstanding;
	int ring_level;
	int chars_checked;
	int pushes_sent = 0;
	int pops_sent = 0;
	int idle_cycles = 0;
	bit steady = 1'b0;

	avr_hex_line_ring_framer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req_ch (req_ch),
		.res_ch (res_ch)
	);

	tb_ahf_line_checker line_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_ch        (req_ch),
		.res_ch        (res_ch),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.ring_level    (ring_level),
		.chars_checked (chars_checked)
	);

	always #6 clk = ~clk;

	function automatic int draw_wait();
		if (steady || $urandom_range(0, 3) == 0) begin
			return 0;
		end
		return $urandom_range(0, 9);
	endfunction

	function automatic req_t frame_req(input cmd_t c, input logic [7:0] bits,
			input logic [63:0] up, input logic [47:0] lo, input logic lis);
		req_t r;
		r.command          = c;
		r.msg_bits         = bits;
		r.msg_upper        = up;
		r.msg_lower        = lo;
		r.listener_present = lis;
		return r;
	endfunction

	function automatic req_t random_push();
		logic [63:0] spare;
		logic [7:0]  bits;
		int          pick;
		spare = {$urandom, $urandom};
		pick  = $urandom_range(0, 99);
		// mostly storable lengths, some too short or too long
		if (pick < 82) begin
			bits = 8'($urandom_range(8, 119));
		end else if (pick < 88) begin
			bits = 8'($urandom_range(0, 7));
		end else begin
			bits = 8'($urandom_range(120, 255));
		end
		return frame_req(CMD_PUSH, bits, {$urandom, $urandom}, spare[47:0],
			$urandom_range(0, 99) < 93);
	endfunction

	function automatic req_t random_pop();
		req_t r;
		r = random_push();
		r.command = CMD_POP;
		return r;
	endfunction

	task automatic send_request(input req_t r);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= r;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (r.command == CMD_PUSH) begin
			pushes_sent++;
		end else begin
			pops_sent++;
		end
	endtask

	task automatic hold_until_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// result side back-pressure
	initial begin
		int stall;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n       <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty ring, rejected pushes, length extremes, pops back to empty
		send_request(frame_req(CMD_POP, 8'h00, 64'h0, 48'h0, 1'b0));
		send_request(frame_req(CMD_POP, 8'hFF, '1, '1, 1'b1));
		send_request(frame_req(CMD_PUSH, 8'd112, '1, '1, 1'b0));
		send_request(frame_req(CMD_PUSH, 8'd0, '1, '1, 1'b0));
		send_request(frame_req(CMD_PUSH, 8'd0, '1, '1, 1'b1));
		send_request(frame_req(CMD_PUSH, 8'd7, '1, '1, 1'b1));
		send_request(frame_req(CMD_PUSH, 8'd120, '1, '1, 1'b1));
		send_request(frame_req(CMD_PUSH, 8'd255, '1, '1, 1'b1));
		send_request(frame_req(CMD_PUSH, 8'd112, '1, '1, 1'b1));
		send_request(frame_req(CMD_PUSH, 8'd8, 64'h0, 48'h0, 1'b1));
		send_request(frame_req(CMD_PUSH, 8'd119, 64'h0123_4567_89AB_CDEF,
			48'hFEDC_BA98_7654, 1'b1));
		send_request(frame_req(CMD_PUSH, 8'd15, 64'hA55A_0000_0000_0000, 48'h0, 1'b1));
		send_request(frame_req(CMD_PUSH, 8'd56, 64'h8D4C_A7E5_58C3_90FF, '1, 1'b1));
		for (int i = 0; i < 5; i++) begin
			send_request(frame_req(CMD_POP, 8'h00, '0, '0, 1'b0));
		end
		send_request(frame_req(CMD_POP, 8'h00, '0, '0, 1'b1));

		// random mix of pushes and pops
		for (int i = 0; i < MIX_ITEMS; i++) begin
			steady = (i >= MIX_ITEMS / 2);
			if ($urandom_range(0, 99) < 55) begin
				send_request(random_push());
			end else begin
				send_request(random_pop());
			end
		end

		// fill the ring, then push into a full ring
		steady = $urandom_range(0, 1);
		while (ring_level < RING_DEPTH) begin
			send_request(frame_req(CMD_PUSH, 8'($urandom_range(8, 119)), {$urandom, $urandom},
				48'($urandom), 1'b1));
		end
		for (int i = 0; i < DROP_ITEMS; i++) begin
			send_request(frame_req(CMD_PUSH, 8'($urandom_range(8, 119)), {$urandom, $urandom},
				48'($urandom), 1'b1));
		end
		steady = 1'b0;
		hold_until_drained();

		// drain to empty and pop past it
		while (ring_level != 0) begin
			steady = (pops_sent % 32) < 16;
			send_request(random_pop());
		end
		steady = 1'b0;
		for (int i = 0; i < 3; i++) begin
			send_request(random_pop());
		end

		for (int i = 0; i < TAIL_ITEMS; i++) begin
			if ($urandom_range(0, 99) < 60) begin
				send_request(random_push());
			end else begin
				send_request(random_pop());
			end
		end

		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("sent %0d pushes and %0d pops, checked %0d results", pushes_sent, pops_sent,
			chars_checked);
		$display("ring was filled to %0d frames, overflowed with drops, then emptied",
			RING_DEPTH);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
